@@ sv/b64d_pkg.sv @@
// Shared types, constants and the symbol lookup for the Base64 stream decoder.
package b64d_pkg;

    localparam int unsigned FIFO_DEPTH_DEF = 4;

    localparam logic [7:0]  PAD_CHAR  = 8'h3D;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } result_kind_t;

    // One queued job: an optional data byte, then an optional end result.
    typedef struct packed {
        logic        has_data;
        logic [7:0]  data;
        logic        has_end;
        logic        end_err;
        logic [23:0] count;
    } job_t;

    // Bit 6 set means the byte is not an alphabet symbol.
    function automatic logic [6:0] symbol_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd64;
        if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B) v = 7'd62;
        else if (c == 8'h2F) v = 7'd63;
        return v;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

@@ sv/b64d_front.sv @@
// Front end: classifies each text byte, tracks symbol phase and padding, builds jobs.
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       space_ok,
    output logic       in_ready,
    output logic       push,
    output job_t       push_job
);

    typedef enum logic [1:0] {
        TAIL_DECODE  = 2'd0,
        TAIL_ONE_PAD = 2'd1,
        TAIL_PADDED  = 2'd2,
        TAIL_DROP    = 2'd3
    } tail_t;

    logic [1:0]  phase_reg, phase_next;
    tail_t       tail_reg, tail_next;
    logic [7:0]  partial_reg, partial_next;
    logic [23:0] count_reg, count_next, count_upd;

    logic       accept;
    logic       err;
    logic       emit;
    logic       end_ok;
    logic [7:0] data_b;
    logic [6:0] sym;

    assign in_ready = space_ok;
    assign accept   = in_valid && space_ok;
    assign sym      = symbol_value(in_byte);

    always_comb
    begin
        phase_next   = phase_reg;
        tail_next    = tail_reg;
        partial_next = partial_reg;
        count_upd    = count_reg;
        err          = 1'b0;
        emit         = 1'b0;
        end_ok       = 1'b0;
        data_b       = '0;
        if (tail_reg != TAIL_DROP)
        begin
            if (!is_space(in_byte))
            begin
                unique case (tail_reg)
                    TAIL_DECODE:
                    begin
                        if (in_byte == PAD_CHAR)
                        begin
                            if (phase_reg == 2'd2)      tail_next = TAIL_ONE_PAD;
                            else if (phase_reg == 2'd3) tail_next = TAIL_PADDED;
                            else                        err = 1'b1;
                        end
                        else if (sym[6])
                        begin
                            err = 1'b1;
                        end
                        else
                        begin
                            case (phase_reg)
                                2'd0:
                                begin
                                    partial_next = {sym[5:0], 2'b00};
                                end
                                2'd1:
                                begin
                                    emit         = 1'b1;
                                    data_b       = partial_reg | {6'b0, sym[5:4]};
                                    partial_next = {sym[3:0], 4'b0000};
                                end
                                2'd2:
                                begin
                                    emit         = 1'b1;
                                    data_b       = partial_reg | {4'b0, sym[5:2]};
                                    partial_next = {sym[1:0], 6'b000000};
                                end
                                default:
                                begin
                                    emit         = 1'b1;
                                    data_b       = partial_reg | {2'b0, sym[5:0]};
                                    partial_next = '0;
                                end
                            endcase
                            phase_next = phase_reg + 2'd1;
                        end
                    end
                    TAIL_ONE_PAD:
                    begin
                        if (in_byte == PAD_CHAR) tail_next = TAIL_PADDED;
                        else                     err = 1'b1;
                    end
                    TAIL_PADDED: err = 1'b1;
                    TAIL_DROP:   err = 1'b1;
                endcase
            end
            if (emit && count_reg != COUNT_MAX)
                count_upd = count_reg + 24'd1;
            // end-of-message checks look at the state after this byte
            if (!err && in_last)
            begin
                if (tail_next == TAIL_DECODE)       err = (phase_next != 2'd0);
                else if (tail_next == TAIL_ONE_PAD) err = 1'b1;
                else                                err = (partial_next != 8'd0);
                end_ok = !err;
            end
            if (err && !in_last)
                tail_next = TAIL_DROP;
        end
        count_next = count_upd;
        if (in_last)
        begin
            phase_next   = '0;
            tail_next    = TAIL_DECODE;
            partial_next = '0;
            count_next   = '0;
        end
    end

    assign push              = accept && (emit || end_ok || err);
    assign push_job.has_data = emit;
    assign push_job.data     = data_b;
    assign push_job.has_end  = end_ok || err;
    assign push_job.end_err  = err;
    assign push_job.count    = count_upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            tail_reg    <= TAIL_DECODE;
            partial_reg <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            tail_reg    <= tail_next;
            partial_reg <= partial_next;
            count_reg   <= count_next;
        end
    end

endmodule

@@ sv/b64d_fifo.sv @@
// Short job queue between the front end and the result sequencer.
module b64d_fifo
    import b64d_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic not_full,
    output logic not_empty,
    output job_t head
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    job_t          slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] fill_reg;

    assign not_full  = (fill_reg != CW'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (push && !pop)
                fill_reg <= fill_reg + CW'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - CW'(1);
        end
    end

endmodule

@@ sv/b64d_back.sv @@
// Back end: expands each job into its results and holds them in the output register.
module b64d_back
    import b64d_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         job_valid,
    input  job_t         job,
    output logic         pop,
    input  logic         out_ready,
    output logic         out_valid,
    output result_kind_t out_kind,
    output logic [7:0]   out_data,
    output logic [23:0]  out_count,
    output logic         out_final
);

    logic         valid_reg;
    logic         data_done_reg;
    result_kind_t kind_reg;
    logic [7:0]   data_reg;
    logic [23:0]  count_reg;
    logic         final_reg;

    logic load;
    logic send_data;

    assign load      = job_valid && (!valid_reg || out_ready);
    assign send_data = job.has_data && !data_done_reg;
    // a job with data and an end stays at the head for a second result
    assign pop       = load && !(send_data && job.has_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            data_done_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg     <= 1'b1;
                data_done_reg <= send_data && job.has_end;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (send_data)
            begin
                kind_reg  <= KIND_DATA;
                data_reg  <= job.data;
                count_reg <= '0;
                final_reg <= 1'b0;
            end
            else
            begin
                kind_reg  <= job.end_err ? KIND_ERR : KIND_OK;
                data_reg  <= '0;
                count_reg <= job.count;
                final_reg <= 1'b1;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_data  = data_reg;
    assign out_count = count_reg;
    assign out_final = final_reg;

endmodule

@@ sv/base64_stream_decoder_unit.sv @@
// Top level of the Base64 stream decoder: front end, job queue and result sequencer.
//
//  channel | direction | tdata                                | tuser           | tlast
//  s_*     | in        | [7:0] text_byte                      | -               | message_end
//  m_*     | out       | [7:0] data_byte, [31:8] decoded_count| [1:0] result_kind | final_result
//
// One text byte is taken per cycle while the job queue has room.
// Results leave one per cycle from the output register while the receiver is ready; a
// byte that yields a data byte and the end result sends both in turn on the single
// result port. Each result passes through the job queue and then the output register.
// Reset clears phase, padding state, byte count, queue and output register.
// Either side may stall; the queue absorbs the difference until full.
module base64_stream_decoder_unit
    import b64d_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // message_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [31:8] decoded_count
    output logic [1:0]  m_tuser,   // [1:0] result_kind
    output logic        m_tlast    // final_result
);

    logic         push;
    job_t         push_job;
    logic         pop;
    logic         not_full;
    logic         not_empty;
    job_t         head;
    result_kind_t kind;
    logic [7:0]   data_byte;
    logic [23:0]  decoded_count;

    b64d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .in_last  (s_tlast),
        .space_ok (not_full),
        .in_ready (s_tready),
        .push     (push),
        .push_job (push_job)
    );

    b64d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_full  (not_full),
        .not_empty (not_empty),
        .head      (head)
    );

    b64d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (not_empty),
        .job       (head),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (kind),
        .out_data  (data_byte),
        .out_count (decoded_count),
        .out_final (m_tlast)
    );

    assign m_tdata = {decoded_count, data_byte};
    assign m_tuser = kind;

endmodule

@@ dv/base64_stream_decoder_unit_tb.sv @@
// Self-checking testbench for the Base64 stream decoder: directed table, random messages.
module base64_stream_decoder_unit_tb;
    import b64d_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [1:0] {
        TAIL_SYMBOLS,
        TAIL_HALF_PAD,
        TAIL_PADDED,
        TAIL_DROPPING
    } pad_state_t;

    typedef struct packed {
        result_kind_t kind;
        logic [7:0]   data;
        logic [23:0]  count;
        logic         fin;
    } b64_result_t;

    // Typed rows carry their single end or error result in kind/count.
    typedef struct packed {
        logic [7:0]   text;
        logic         last;
        logic         typed;
        result_kind_t kind;
        logic [23:0]  count;
    } text_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    base64_stream_decoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // decoder state mirrored by the predictor
    logic [1:0]  sym_phase;
    pad_state_t  pad_state;
    logic [7:0]  held_bits;
    logic [23:0] msg_count;
    b64_result_t step_res [2];
    int          step_n;

    b64_result_t pending_results [$];
    text_item_t  send_q [$];
    text_item_t  script [24];
    int          mismatch_count;
    int          results_seen;
    int          cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] symbol_char(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + 8'(v);
        if (v < 6'd52) return 8'h61 + 8'(v) - 8'd26;
        if (v < 6'd62) return 8'h30 + 8'(v) - 8'd52;
        return (v == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic logic sextet_of(input logic [7:0] c, output logic [5:0] v);
        v = 6'd0;
        for (int k = 0; k < 64; k++)
        begin
            if (symbol_char(6'(k)) == c)
            begin
                v = 6'(k);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [7:0] blank_char();
        int n;
        n = $urandom_range(0, 5);
        return (n == 5) ? 8'h20 : 8'h09 + 8'(n);
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic clear_decoder();
        sym_phase = 2'd0;
        pad_state = TAIL_SYMBOLS;
        held_bits = 8'h00;
        msg_count = 24'd0;
    endtask

    task automatic add_result(input result_kind_t kind, input logic [7:0] data);
        step_res[step_n] = '{kind: kind, data: data,
                             count: (kind == KIND_DATA) ? 24'd0 : msg_count,
                             fin: (kind != KIND_DATA)};
        step_n++;
    endtask

    // Computes the results of one accepted text byte into step_res/step_n.
    task automatic decode_text_byte(input logic [7:0] c, input logic last);
        logic       bad;
        logic [5:0] s;
        logic [7:0] out;
        step_n = 0;
        bad = 1'b0;
        if (pad_state == TAIL_DROPPING)
        begin
            if (last)
                clear_decoder();
            return;
        end
        if (!(c inside {[8'h09:8'h0D], 8'h20}))
        begin
            case (pad_state)
                TAIL_SYMBOLS:
                begin
                    if (c == PAD_CHAR)
                    begin
                        if (sym_phase == 2'd2)
                            pad_state = TAIL_HALF_PAD;
                        else if (sym_phase == 2'd3)
                            pad_state = TAIL_PADDED;
                        else
                            bad = 1'b1;
                    end
                    else if (!sextet_of(c, s))
                        bad = 1'b1;
                    else
                    begin
                        out = 8'h00;
                        case (sym_phase)
                            2'd0: held_bits = {s, 2'b00};
                            2'd1:
                            begin
                                out = held_bits | {6'd0, s[5:4]};
                                held_bits = {s[3:0], 4'd0};
                            end
                            2'd2:
                            begin
                                out = held_bits | {4'd0, s[5:2]};
                                held_bits = {s[1:0], 6'd0};
                            end
                            default:
                            begin
                                out = held_bits | {2'd0, s};
                                held_bits = 8'h00;
                            end
                        endcase
                        if (sym_phase != 2'd0)
                        begin
                            add_result(KIND_DATA, out);
                            if (msg_count != COUNT_MAX)
                                msg_count++;
                        end
                        sym_phase = sym_phase + 2'd1;
                    end
                end
                TAIL_HALF_PAD:
                    if (c != PAD_CHAR)
                        bad = 1'b1;
                    else
                        pad_state = TAIL_PADDED;
                default:
                    bad = 1'b1;
            endcase
        end
        if (!bad && last)
        begin
            case (pad_state)
                TAIL_SYMBOLS:  bad = (sym_phase != 2'd0);
                TAIL_HALF_PAD: bad = 1'b1;
                default:       bad = (held_bits != 8'h00);
            endcase
            if (!bad)
            begin
                add_result(KIND_OK, 8'h00);
                clear_decoder();
                return;
            end
        end
        if (bad)
        begin
            add_result(KIND_ERR, 8'h00);
            if (last)
                clear_decoder();
            else
                pad_state = TAIL_DROPPING;
        end
    endtask

    // One random message: mostly valid encodings with stray whitespace, some broken.
    task automatic queue_message(output int added);
        logic [7:0]  raw [$];
        logic [7:0]  txt [$];
        logic [23:0] grp;
        int          len;
        int          n;
        int          pos;
        int          start;
        start = send_q.size();
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 6);
        repeat (len)
            raw.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i += 3)
        begin
            n = (len - i > 3) ? 3 : len - i;
            grp = {raw[i], (n > 1) ? raw[i + 1] : 8'h00, (n > 2) ? raw[i + 2] : 8'h00};
            txt.push_back(symbol_char(grp[23:18]));
            txt.push_back(symbol_char(grp[17:12]));
            txt.push_back((n > 1) ? symbol_char(grp[11:6]) : PAD_CHAR);
            txt.push_back((n > 2) ? symbol_char(grp[5:0]) : PAD_CHAR);
        end
        case ($urandom_range(0, 9))
            6:
                while (txt.size() > 0 && txt[txt.size() - 1] == PAD_CHAR)
                    void'(txt.pop_back());
            7:
            begin
                pos = $urandom_range(0, txt.size());
                txt.insert(pos, 8'($urandom_range(0, 255)));
            end
            8:
                // disturb the symbol ahead of the padding so leftover bits may be set
                if (txt.size() > 0 && txt[txt.size() - 1] == PAD_CHAR)
                begin
                    pos = txt.size() - 1;
                    while (pos > 0 && txt[pos] == PAD_CHAR)
                        pos--;
                    txt[pos] = symbol_char(6'($urandom_range(0, 63)));
                end
            9:
            begin
                txt.delete();
                repeat ($urandom_range(1, 8))
                    txt.push_back(8'($urandom_range(0, 255)));
            end
            default:
                ;
        endcase
        foreach (txt[k])
        begin
            if ($urandom_range(0, 7) == 0)
                send_q.push_back('{blank_char(), 1'b0, 1'b0, KIND_DATA, 24'd0});
            send_q.push_back('{txt[k], 1'b0, 1'b0, KIND_DATA, 24'd0});
        end
        if ($urandom_range(0, 5) == 0 || send_q.size() == start)
            send_q.push_back('{blank_char(), 1'b0, 1'b0, KIND_DATA, 24'd0});
        send_q[send_q.size() - 1].last = 1'b1;
        added = send_q.size() - start;
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // sender and end of run
    initial
    begin
        text_item_t  item;
        b64_result_t want;
        int          calm;
        int          wait_n;
        int          random_count;
        int          n;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        mismatch_count = 0;
        calm = 0;
        random_count = 0;
        clear_decoder();
        script = '{
            '{8'h3D, 1'b0, 1'b1, KIND_ERR,  24'd0},  // pad in phase 0
            '{8'h41, 1'b1, 1'b0, KIND_DATA, 24'd0},  // dropped, end clears
            '{8'h00, 1'b1, 1'b1, KIND_ERR,  24'd0},  // NUL is invalid
            '{8'h09, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h0D, 1'b1, 1'b1, KIND_OK,   24'd0},  // whitespace-only message
            '{8'h51, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h51, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h3D, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h20, 1'b0, 1'b0, KIND_DATA, 24'd0},  // space between the two pads
            '{8'h3D, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h0A, 1'b1, 1'b1, KIND_OK,   24'd1},
            '{8'h2F, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h2B, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h39, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h7A, 1'b1, 1'b0, KIND_DATA, 24'd0},  // data byte, then end result
            '{8'h51, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h52, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h3D, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h3D, 1'b1, 1'b1, KIND_ERR,  24'd1},  // leftover bits not zero
            '{8'hFF, 1'b1, 1'b1, KIND_ERR,  24'd0},
            '{8'h61, 1'b1, 1'b1, KIND_ERR,  24'd0},  // unpadded end in phase 1
            '{8'h30, 1'b0, 1'b0, KIND_DATA, 24'd0},
            '{8'h3D, 1'b0, 1'b1, KIND_ERR,  24'd0},  // pad in phase 1
            '{8'h5A, 1'b1, 1'b0, KIND_DATA, 24'd0}
        };
        foreach (script[i])
            send_q.push_back(script[i]);
        while (random_count < RANDOM_ITEMS)
        begin
            queue_message(n);
            random_count += n;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        while (send_q.size() > 0)
        begin
            item = send_q.pop_front();
            wait_n = draw_wait(calm);
            if (wait_n > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= item.text;
            s_tlast <= item.last;
            do @(posedge clk); while (s_tready !== 1'b1);
            decode_text_byte(item.text, item.last);
            if (item.typed)
            begin
                want = '{kind: item.kind, data: 8'h00, count: item.count, fin: 1'b1};
                pending_results.push_back(want);
            end
            else
            begin
                for (int k = 0; k < step_n; k++)
                    pending_results.push_back(step_res[k]);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, calm stretches and one long hold to back up the queue
    initial
    begin
        int  calm;
        int  wait_n;
        bit  held_long;
        m_tready = 1'b0;
        calm = 0;
        held_long = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held_long && results_seen >= 150)
            begin
                held_long = 1'b1;
                wait_n = LONG_HOLD;
            end
            else
                wait_n = draw_wait(calm);
            if (wait_n > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    always @(posedge clk)
    begin
        b64_result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch($sformatf("unexpected transfer kind %0d data %02h count %0d",
                                          m_tuser, m_tdata[7:0], m_tdata[31:8]));
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch($sformatf("kind got %0d want %0d", m_tuser, want.kind));
                if (m_tdata[7:0] !== want.data)
                    report_mismatch($sformatf("data got %02h want %02h",
                                              m_tdata[7:0], want.data));
                if (m_tdata[31:8] !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              m_tdata[31:8], want.count));
                if (m_tlast !== want.fin)
                    report_mismatch($sformatf("final got %0b want %0b", m_tlast, want.fin));
            end
        end
    end

    initial
    begin
        cycles = 0;
        results_seen = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TIMEOUT after %0d cycles, %0d results outstanding",
                 cycles, pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
